// ===== design/wdns_pkg.sv =====
// Shared types and constants for the wave dispersion Newton solver.
// Used by wdns_alu and wave_dispersion_newton_solver; no dependencies.
`default_nettype none
package wdns_pkg;

   // guard precision of the exp/tanh path
   localparam int unsigned GUARD_BITS = 40;
   localparam logic [63:0] LN2_Q40    = 64'h0000_00B1_7217_F7D2;
   localparam logic [63:0] ONE_Q40    = 64'h0000_0100_0000_0000;
   localparam logic [63:0] DEEP_A40   = 64'h0000_2000_0000_0000;   // 32.0 in Q.40
   localparam logic [4:0]  EXP_TERMS  = 5'd16;
   localparam logic [63:0] X_LIMIT    = 64'd64;

   // configuration register indexes
   localparam logic [1:0] CSR_DEPTH   = 2'd0;
   localparam logic [1:0] CSR_GRAVITY = 2'd1;
   localparam logic [1:0] CSR_TOL     = 2'd2;

   typedef enum logic {
      ALU_MUL,
      ALU_DIV
   } alu_op_type;

   // request to the shared multiply/divide unit
   typedef struct packed {
      logic         start;
      alu_op_type   op;
      logic [127:0] opa;   // dividend, or multiplicand in [63:0]
      logic [63:0]  opb;   // divisor, or multiplier
   } alu_req_type;

   // response: full product or 128-bit quotient
   typedef struct packed {
      logic         done;
      logic [127:0] res;
   } alu_rsp_type;

endpackage
`default_nettype wire

// ===== design/wdns_alu.sv =====
// Shared bit-serial arithmetic unit: 64x64 multiply and
// 128/64 restoring divide. Depends on wdns_pkg.
`default_nettype none
module wdns_alu
   import wdns_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire alu_req_type req,
   output alu_rsp_type      rsp
);

   logic         busy_ff;
   logic         done_ff;
   alu_op_type   op_ff;
   logic [6:0]   cnt_ff;
   logic [127:0] acc_ff;
   logic [63:0]  b_ff;
   logic [63:0]  rem_ff;

   logic [64:0]  mul_sum;
   logic [63:0]  rem_sh;
   logic         rem_ge;

   // one multiply step: add multiplicand on low bit, shift right
   assign mul_sum = {1'b0, acc_ff[127:64]} + (acc_ff[0] ? {1'b0, b_ff} : 65'd0);

   // one divide step: shift in next dividend bit, trial subtract
   assign rem_sh = {rem_ff[62:0], acc_ff[127]};
   assign rem_ge = (rem_sh >= b_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (!busy_ff) begin
            if (req.start) begin
               busy_ff <= 1'b1;
               op_ff   <= req.op;
               rem_ff  <= 64'd0;
               if (req.op == ALU_MUL) begin
                  cnt_ff <= 7'd63;
                  acc_ff <= {64'd0, req.opb};
                  b_ff   <= req.opa[63:0];
               end else begin
                  cnt_ff <= 7'd127;
                  acc_ff <= req.opa;
                  b_ff   <= req.opb;
               end
            end
         end else begin
            if (op_ff == ALU_MUL) begin
               acc_ff <= {mul_sum, acc_ff[63:1]};
            end else begin
               rem_ff <= rem_ge ? (rem_sh - b_ff) : rem_sh;
               acc_ff <= {acc_ff[126:0], rem_ge};
            end
            cnt_ff <= cnt_ff - 7'd1;
            if (cnt_ff == 7'd0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign rsp.done = done_ff;
   assign rsp.res  = acc_ff;

endmodule
`default_nettype wire

// ===== design/wave_dispersion_newton_solver.sv =====
// Top level: water-wave dispersion solver (Newton-Raphson on A = X tanh X).
// Depends on wdns_pkg and wdns_alu.
//
//   channel | direction | ports                         | transfer when
//   req     | in        | req_valid/req_stall + payload | valid && !stall
//   rsp     | out       | rsp_valid/rsp_stall + payload | valid && !stall
//   csr     | in        | csr_wr_en/index/data          | wr_en
//
// One item at a time; multiplies and divides run on the shared serial unit.
// Infinite depth and effectively deep water take the short deep-water path.
// Finite depth: N Newton updates, N <= MAX_NEWTON_STEPS;
// the 16-term exp series (a multiply and a divide per term) dominates each step,
// and the split of 2x by ln2 is done bit by bit with compare and subtract.
// Synchronous reset restores the register defaults; req_stall is high while busy,
// and a stalled result holds until taken.
`default_nettype none
module wave_dispersion_newton_solver
   import wdns_pkg::*;
#(
   parameter int unsigned MAX_NEWTON_STEPS = 32,
   parameter int unsigned FRAC_BITS        = 24
)
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [31:0] req_angular_freq,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [31:0]      rsp_wavenumber,
   output logic             rsp_converged,
   output logic             rsp_saturated,
   input  wire logic        csr_wr_en,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_wr_data
);

   localparam int unsigned STEP_W = $clog2(MAX_NEWTON_STEPS + 1);
   localparam int unsigned TOL_UP = (FRAC_BITS >= 24) ? FRAC_BITS - 24 : 0;
   localparam int unsigned TOL_DN = (FRAC_BITS >= 24) ? 0 : 24 - FRAC_BITS;
   localparam int unsigned Y_SH   = GUARD_BITS - FRAC_BITS;
   localparam int unsigned A_SH   = GUARD_BITS - FRAC_BITS;
   localparam int unsigned K_SH   = 32 - FRAC_BITS;
   localparam logic [63:0] ONE_F  = 64'd1 << FRAC_BITS;
   localparam logic [63:0] XCAP   = X_LIMIT << FRAC_BITS;
   localparam logic [STEP_W-1:0] STEP_MAX = STEP_W'(MAX_NEWTON_STEPS);

   typedef enum logic [3:0] {
      S_IDLE, S_OM2, S_AH, S_AG, S_DEEP, S_T_N, S_E_MUL, S_E_DIV,
      S_T_DIV, S_R_MUL, S_D1, S_D2, S_D3, S_K, S_OUT
   } state_type;

   state_type   state_ff;
   logic        issued_ff;

   // configuration registers
   logic [31:0] depth_ff;
   logic [31:0] grav_ff;
   logic [15:0] tol_ff;

   // working registers
   logic [31:0]  om_ff;
   logic [63:0]  om2_ff;
   logic [127:0] prod_ff;
   logic [63:0]  a_fix_ff;
   logic [63:0]  x_ff;
   logic [63:0]  th_ff;
   logic [63:0]  r_ff;
   logic [7:0]   n_ff;
   logic [2:0]   nbit_ff;
   logic [63:0]  sum_ff;
   logic [63:0]  term_ff;
   logic [4:0]   kidx_ff;
   logic [63:0]  res_ff;
   logic [63:0]  tmp_ff;
   logic [STEP_W-1:0] step_ff;
   logic         conv_ff;
   logic [31:0]  wave_ff;
   logic         sat_ff;

   alu_req_type alu_req;
   alu_rsp_type alu_rsp;

   logic [31:0] g_eff;
   logic [63:0] tol64;
   logic [63:0] mul_f;
   logic [63:0] mul_g;
   logic [63:0] div_q;
   logic [63:0] res_c;
   logic [63:0] mag_c;
   logic [63:0] mag_ff_abs;
   logic [63:0] e_c;
   logic [63:0] y_c;
   logic [63:0] d_c;
   logic [63:0] delta_c;
   logic [63:0] x_next;
   logic [63:0] term_next;
   logic [63:0] ln2_sh;
   logic        ln2_fit;

   wdns_alu u_alu (
      .clock (clock),
      .reset (reset),
      .req   (alu_req),
      .rsp   (alu_rsp)
   );

   // derived values
   assign g_eff      = (grav_ff == 32'd0) ? 32'd1 : grav_ff;
   assign tol64      = ({48'd0, tol_ff} << TOL_UP) >> TOL_DN;
   assign mul_f      = 64'(alu_rsp.res >> FRAC_BITS);
   assign mul_g      = 64'(alu_rsp.res >> GUARD_BITS);
   assign div_q      = (|alu_rsp.res[127:64]) ? {64{1'b1}} : alu_rsp.res[63:0];
   assign res_c      = a_fix_ff - mul_f;
   assign mag_c      = res_c[63] ? (64'd0 - res_c) : res_c;
   assign mag_ff_abs = res_ff[63] ? (64'd0 - res_ff) : res_ff;
   assign e_c        = (|n_ff[7:6]) ? 64'd0 : (sum_ff >> n_ff[5:0]);
   assign y_c        = (x_ff << 1) << Y_SH;
   assign d_c        = th_ff + mul_f;
   assign delta_c    = (div_q > XCAP) ? XCAP : div_q;
   assign term_next  = alu_rsp.res[63:0];

   // 2x / ln2: one quotient bit per cycle, 2x stays below 256 ln2
   assign ln2_sh     = LN2_Q40 << nbit_ff;
   assign ln2_fit    = (r_ff >= ln2_sh);

   // Newton update of X, held within [0, 64]
   always_comb begin
      if (!res_ff[63] && (res_ff != 64'd0)) begin
         x_next = ((x_ff + delta_c) > XCAP) ? XCAP : (x_ff + delta_c);
      end else begin
         x_next = (delta_c >= x_ff) ? 64'd0 : (x_ff - delta_c);
      end
   end

   // operand selection for the shared unit
   always_comb begin
      alu_req.start = 1'b0;
      alu_req.op    = ALU_MUL;
      alu_req.opa   = 128'd0;
      alu_req.opb   = 64'd0;
      case (state_ff)
         S_OM2: begin
            alu_req.opa = {96'd0, om_ff};
            alu_req.opb = {32'd0, om_ff};
         end
         S_AH: begin
            alu_req.opa = {64'd0, om2_ff};
            alu_req.opb = {32'd0, depth_ff};
         end
         S_AG: begin
            alu_req.op  = ALU_DIV;
            alu_req.opa = prod_ff;
            alu_req.opb = {32'd0, g_eff};
         end
         S_DEEP: begin
            alu_req.op  = ALU_DIV;
            alu_req.opa = {64'd0, om2_ff};
            alu_req.opb = {24'd0, g_eff, 8'd0};
         end
         S_E_MUL: begin
            alu_req.opa = {64'd0, term_ff};
            alu_req.opb = r_ff;
         end
         S_E_DIV: begin
            alu_req.op  = ALU_DIV;
            alu_req.opa = {64'd0, term_ff};
            alu_req.opb = {59'd0, kidx_ff};
         end
         S_T_DIV: begin
            alu_req.op  = ALU_DIV;
            alu_req.opa = {64'd0, ONE_Q40 - e_c} << FRAC_BITS;
            alu_req.opb = ONE_Q40 + e_c;
         end
         S_R_MUL: begin
            alu_req.opa = {64'd0, x_ff};
            alu_req.opb = th_ff;
         end
         S_D1: begin
            alu_req.opa = {64'd0, th_ff};
            alu_req.opb = th_ff;
         end
         S_D2: begin
            alu_req.opa = {64'd0, x_ff};
            alu_req.opb = tmp_ff;
         end
         S_D3: begin
            alu_req.op  = ALU_DIV;
            alu_req.opa = {64'd0, mag_ff_abs} << FRAC_BITS;
            alu_req.opb = tmp_ff;
         end
         S_K: begin
            alu_req.op  = ALU_DIV;
            alu_req.opa = {64'd0, x_ff << K_SH};
            alu_req.opb = {32'd0, depth_ff};
         end
         default: begin
            alu_req.op = ALU_MUL;
         end
      endcase
      if ((state_ff != S_IDLE) && (state_ff != S_OUT) && (state_ff != S_T_N) &&
          !issued_ff) begin
         alu_req.start = 1'b1;
      end
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff <= 32'd0;
         grav_ff  <= 32'd164584489;
         tol_ff   <= 16'd17;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_DEPTH:   depth_ff <= csr_wr_data;
            CSR_GRAVITY: grav_ff  <= csr_wr_data;
            CSR_TOL:     tol_ff   <= csr_wr_data[15:0];
            default:     ;
         endcase
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         issued_ff <= 1'b0;
      end else begin
         if (alu_req.start) begin
            issued_ff <= 1'b1;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  om_ff    <= req_angular_freq;
                  state_ff <= S_OM2;
               end
            end
            S_OM2: begin
               if (alu_rsp.done) begin
                  issued_ff <= 1'b0;
                  om2_ff    <= alu_rsp.res[63:0];
                  state_ff  <= (depth_ff == 32'd0) ? S_DEEP : S_AH;
               end
            end
            S_AH: begin
               if (alu_rsp.done) begin
                  issued_ff <= 1'b0;
                  prod_ff   <= alu_rsp.res;
                  state_ff  <= S_AG;
               end
            end
            S_AG: begin
               if (alu_rsp.done) begin
                  issued_ff <= 1'b0;
                  a_fix_ff  <= div_q >> A_SH;
                  x_ff      <= div_q >> A_SH;
                  step_ff   <= '0;
                  state_ff  <= (div_q >= DEEP_A40) ? S_DEEP : S_T_N;
               end
            end
            S_DEEP: begin
               if (alu_rsp.done) begin
                  issued_ff <= 1'b0;
                  conv_ff   <= 1'b1;
                  sat_ff    <= |div_q[63:32];
                  wave_ff   <= (|div_q[63:32]) ? 32'hFFFF_FFFF : div_q[31:0];
                  state_ff  <= S_OUT;
               end
            end
            // tanh: split 2x into n ln2 + r by compare and subtract
            S_T_N: begin
               if (!issued_ff) begin
                  issued_ff <= 1'b1;
                  r_ff      <= y_c;
                  n_ff      <= 8'd0;
                  nbit_ff   <= 3'd7;
               end else begin
                  if (ln2_fit) begin
                     r_ff          <= r_ff - ln2_sh;
                     n_ff[nbit_ff] <= 1'b1;
                  end
                  if (nbit_ff == 3'd0) begin
                     issued_ff <= 1'b0;
                     sum_ff    <= ONE_Q40;
                     term_ff   <= ONE_Q40;
                     kidx_ff   <= 5'd1;
                     state_ff  <= S_E_MUL;
                  end else begin
                     nbit_ff <= nbit_ff - 3'd1;
                  end
               end
            end
            S_E_MUL: begin
               if (alu_rsp.done) begin
                  issued_ff <= 1'b0;
                  term_ff   <= mul_g;
                  state_ff  <= S_E_DIV;
               end
            end
            // next Taylor term of exp(-r), alternating sign
            S_E_DIV: begin
               if (alu_rsp.done) begin
                  issued_ff <= 1'b0;
                  term_ff   <= term_next;
                  sum_ff    <= kidx_ff[0] ? (sum_ff - term_next) : (sum_ff + term_next);
                  if (kidx_ff == EXP_TERMS) begin
                     state_ff <= S_T_DIV;
                  end else begin
                     kidx_ff  <= kidx_ff + 5'd1;
                     state_ff <= S_E_MUL;
                  end
               end
            end
            S_T_DIV: begin
               if (alu_rsp.done) begin
                  issued_ff <= 1'b0;
                  th_ff     <= div_q;
                  state_ff  <= S_R_MUL;
               end
            end
            // residue and stop test
            S_R_MUL: begin
               if (alu_rsp.done) begin
                  issued_ff <= 1'b0;
                  res_ff    <= res_c;
                  if (mag_c <= tol64) begin
                     conv_ff  <= 1'b1;
                     state_ff <= S_K;
                  end else if (step_ff >= STEP_MAX) begin
                     conv_ff  <= 1'b0;
                     state_ff <= S_K;
                  end else begin
                     step_ff  <= step_ff + 1'b1;
                     state_ff <= S_D1;
                  end
               end
            end
            S_D1: begin
               if (alu_rsp.done) begin
                  issued_ff <= 1'b0;
                  tmp_ff    <= ONE_F - mul_f;
                  state_ff  <= S_D2;
               end
            end
            // derivative, a zero one taken as one ulp
            S_D2: begin
               if (alu_rsp.done) begin
                  issued_ff <= 1'b0;
                  tmp_ff    <= (d_c == 64'd0) ? 64'd1 : d_c;
                  state_ff  <= S_D3;
               end
            end
            S_D3: begin
               if (alu_rsp.done) begin
                  issued_ff <= 1'b0;
                  x_ff      <= x_next;
                  state_ff  <= S_T_N;
               end
            end
            S_K: begin
               if (alu_rsp.done) begin
                  issued_ff <= 1'b0;
                  sat_ff    <= |div_q[63:32];
                  wave_ff   <= (|div_q[63:32]) ? 32'hFFFF_FFFF : div_q[31:0];
                  state_ff  <= S_OUT;
               end
            end
            S_OUT: begin
               if (!rsp_stall) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_stall      = (state_ff != S_IDLE);
   assign rsp_valid      = (state_ff == S_OUT);
   assign rsp_wavenumber = wave_ff;
   assign rsp_converged  = conv_ff;
   assign rsp_saturated  = sat_ff;

endmodule
`default_nettype wire
